### hdl/gnma_pkg.sv
`default_nettype none

package gnma_pkg;

   localparam int NODE_W    = 6;
   localparam int MODE_W    = 2;
   localparam int NODES_DEF = 64;

   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MERGE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LIST  = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic [NODE_W-1:0] node_new;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] neighbour;
      logic              has_neighbour;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic              shift;
      logic              add_en;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COLLECT,
      ST_APPLY,
      ST_EMIT,
      ST_EMPTY
   } state_type;

endpackage

`default_nettype wire

### hdl/gnma_cell.sv
`default_nettype none

module gnma_cell #(
   parameter int NODES = gnma_pkg::NODES_DEF,
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gnma_pkg::cell_ctl_type ctl,
   input  logic [NODES-1:0]      nbr_row,
   output logic [NODES-1:0]      row_out
);
   import gnma_pkg::*;

   localparam logic [NODE_W-1:0] SELF = NODE_W'(INDEX);
   localparam logic [NODES-1:0]  ONE  = {{(NODES-1){1'b0}}, 1'b1};

   logic [NODES-1:0] row_ff;
   logic [NODES-1:0] row_in;
   logic [NODES-1:0] bit_a;
   logic [NODES-1:0] bit_b;

   assign bit_a   = ONE << ctl.node_a;
   assign bit_b   = ONE << ctl.node_b;
   assign row_out = row_ff;

   always_comb begin
      row_in = row_ff;
      if (ctl.shift) begin
         row_in = nbr_row;
      end else if (ctl.add_en) begin
         if (ctl.node_a == SELF) begin
            row_in = row_in | bit_b;
         end
         if (ctl.node_b == SELF) begin
            row_in = row_in | bit_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

### hdl/graph_node_merge_adjacency_top.sv
// Adjacency store for an undirected graph with edge contraction.
// req channel: one beat carries mode, node_a, node_b, node_new. An add (mode 0)
// updates both rows in the cycle of acceptance and the block is ready again in
// the next cycle. A merge (mode 1) rotates the ring of row cells twice: one pass
// collects both rows, one pass rewrites every row. A listing (mode 2) rotates
// once to fetch the row, then scans it one bit per cycle, pausing while a found
// neighbour waits on rsp_stall, and sends one rsp beat per neighbour in
// ascending order. An empty row gives a single beat with has_neighbour clear.
// Mode 3 is accepted and dropped.
// In the ring rotation one row passes the head cell per cycle.
// req_stall is high while an operation is in progress.
// rsp comes from an output register; while rsp_stall is high the beat holds and
// the scan waits on the next neighbour. Reset clears the graph and the control
// state.
`default_nettype none

module graph_node_merge_adjacency_top #(
   parameter int NODES = gnma_pkg::NODES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gnma_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gnma_pkg::rsp_type rsp_data
);
   import gnma_pkg::*;

   localparam int               CNT_W = $clog2(NODES);
   localparam logic [CNT_W-1:0] T_END = CNT_W'(NODES - 1);
   localparam logic [NODES-1:0] ONE   = {{(NODES-1){1'b0}}, 1'b1};

   state_type        state_ff, state_in;
   req_type          cmd_ff, cmd_in;
   logic [CNT_W-1:0] t_ff, t_in;
   logic [NODES-1:0] acc_ff, acc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_load;

   logic             req_accept;
   logic             slot_free;
   logic             last_step;
   logic             shift_en;
   logic [NODE_W-1:0] t_node;
   logic [NODES-1:0] head_row;
   logic [NODES-1:0] apply_row;
   logic [NODES-1:0] tail_row;
   logic [NODES-1:0] drop;
   logic [NODES-1:0] bit_m;
   logic [NODES-1:0] uni;
   logic             rest_zero;
   cell_ctl_type     cell_ctl;
   logic [NODES-1:0] rows [NODES];

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign last_step  = (t_ff == T_END);
   assign t_node     = NODE_W'(t_ff);
   assign head_row   = rows[0];
   assign drop       = (ONE << cmd_ff.node_a) | (ONE << cmd_ff.node_b);
   assign bit_m      = ONE << cmd_ff.node_new;
   assign uni        = acc_ff & ~drop;
   assign rest_zero  = ((acc_ff >> 1) == '0);
   assign cmd_in     = req_accept ? req_data : cmd_ff;

   assign cell_ctl.shift  = shift_en;
   assign cell_ctl.add_en = req_accept && (req_data.mode == MODE_ADD);
   assign cell_ctl.node_a = req_data.node_a;
   assign cell_ctl.node_b = req_data.node_b;

   always_comb begin
      if (t_node == cmd_ff.node_new) begin
         apply_row = uni;
      end else if ((t_node == cmd_ff.node_a) || (t_node == cmd_ff.node_b)) begin
         apply_row = '0;
      end else if (uni[t_ff]) begin
         apply_row = (head_row & ~drop) | bit_m;
      end else begin
         apply_row = head_row;
      end
   end

   assign tail_row = (state_ff == ST_APPLY) ? apply_row : head_row;

   for (genvar i = 0; i < NODES; i++) begin : g_cell
      if (i == NODES - 1) begin : g_tail
         gnma_cell #(.NODES(NODES), .INDEX(i)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctl     (cell_ctl),
            .nbr_row (tail_row),
            .row_out (rows[i])
         );
      end else begin : g_body
         gnma_cell #(.NODES(NODES), .INDEX(i)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctl     (cell_ctl),
            .nbr_row (rows[i+1]),
            .row_out (rows[i])
         );
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept &&
                ((req_data.mode == MODE_MERGE) || (req_data.mode == MODE_LIST))) begin
               state_in = ST_COLLECT;
            end
         end
         ST_COLLECT: begin
            if (last_step) begin
               if (cmd_ff.mode == MODE_MERGE) begin
                  state_in = ST_APPLY;
               end else if (acc_in == '0) begin
                  state_in = ST_EMPTY;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_APPLY: begin
            if (last_step) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (acc_ff[0] && slot_free && rest_zero) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      shift_en = 1'b0;
      acc_in   = acc_ff;
      t_in     = t_ff;
      rsp_load = 1'b0;
      rsp_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               acc_in = '0;
               t_in   = '0;
            end
         end
         ST_COLLECT: begin
            shift_en = 1'b1;
            t_in     = last_step ? '0 : t_ff + 1'b1;
            if ((t_node == cmd_ff.node_a) ||
                ((cmd_ff.mode == MODE_MERGE) && (t_node == cmd_ff.node_b))) begin
               acc_in = acc_ff | head_row;
            end
         end
         ST_APPLY: begin
            shift_en = 1'b1;
            t_in     = last_step ? '0 : t_ff + 1'b1;
         end
         ST_EMIT: begin
            if (!acc_ff[0] || slot_free) begin
               acc_in = acc_ff >> 1;
               t_in   = t_ff + 1'b1;
               if (acc_ff[0]) begin
                  rsp_load             = 1'b1;
                  rsp_in.neighbour     = t_node;
                  rsp_in.has_neighbour = 1'b1;
                  rsp_in.last          = rest_zero;
                  if (rest_zero) begin
                     t_in = '0;
                  end
               end
            end
         end
         ST_EMPTY: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               rsp_in.last = 1'b1;
            end
         end
         default: begin
            t_in = '0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         t_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         t_ff         <= t_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      acc_ff <= acc_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> acc_ff != '0)
      else $error("scan running on an empty row");

   a_idle_counter: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> t_ff == '0)
      else $error("row counter not home while idle");

   a_apply_full_pass: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) && (state_in != ST_APPLY) |-> last_step)
      else $error("rewrite pass left before the ring came home");

   a_load_free_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> slot_free)
      else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire
